>>> sv/kwtbl_pkg.sv
// shared types, constants and helpers for the keyword table with bracket matching
`default_nettype none

package kwtbl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  // common width for comparing the 6-bit start index against the fill count
  localparam int START_CMP_W = (CNT_W > 6) ? CNT_W : 6;
  // common width for saturating the tally into the 7-bit count field
  localparam int SAT_W       = (CNT_W > 7) ? CNT_W : 7;
  localparam int COUNT_MAX   = 127;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_COUNT  = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_BAD_START = 2'd3;

  // keyword kinds
  localparam logic [3:0] KIND_NONE   = 4'd0;
  localparam logic [3:0] KIND_DO     = 4'd1;
  localparam logic [3:0] KIND_DONE   = 4'd2;
  localparam logic [3:0] KIND_IF     = 4'd3;
  localparam logic [3:0] KIND_THEN   = 4'd4;
  localparam logic [3:0] KIND_FI     = 4'd5;
  localparam logic [3:0] KIND_CASE   = 4'd6;
  localparam logic [3:0] KIND_ESAC   = 4'd7;
  localparam logic [3:0] KIND_OBRACE = 4'd8;
  localparam logic [3:0] KIND_CBRACE = 4'd9;
  localparam logic [3:0] KIND_OPAREN = 4'd10;
  localparam logic [3:0] KIND_CPAREN = 4'd11;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  kw_kind;
    logic [15:0] entry_offset;
    logic [11:0] entry_line;
    logic [7:0]  entry_indent;
    logic [5:0]  start_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count_out;
    logic [5:0]  match_index;
    logic [15:0] match_offset;
    logic [11:0] match_line;
    logic [7:0]  match_indent;
  } out_word_t;

  // one stored keyword record
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] offset;
    logic [11:0] line;
    logic [7:0]  indent;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // finished result from the sequencer to the output stage
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } seq_res_t;

  // closer paired with an opener, none when the kind opens nothing
  function automatic logic [3:0] closer_of(input logic [3:0] kind);
    logic [3:0] c;
    c = KIND_NONE;
    unique case (kind)
      KIND_DO:     c = KIND_DONE;
      KIND_IF:     c = KIND_FI;
      KIND_THEN:   c = KIND_FI;
      KIND_CASE:   c = KIND_ESAC;
      KIND_OBRACE: c = KIND_CBRACE;
      KIND_OPAREN: c = KIND_CPAREN;
      default:     c = KIND_NONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/kwtbl_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module kwtbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/kwtbl_seq.sv
// request sequencer: fill count, scan counter and shared compare unit over the table
`default_nettype none

module kwtbl_seq
  import kwtbl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output seq_res_t         res,
  input  wire logic        res_take,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output rec_t             ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  wire rec_t        ram_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_FOPEN,
    ST_FKIND,
    ST_FSCAN,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] didx_r, didx_nxt;
  logic [CNT_W-1:0] tally_r, tally_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [3:0]       kind_r, kind_nxt;
  logic [3:0]       open_r, open_nxt;
  logic [3:0]       close_r, close_nxt;
  out_word_t        res_r, res_nxt;
  logic [3:0]       close_k;
  logic             more;

  assign in_stall  = (state_r != ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.word  = res_r;

  // ram side: append writes at the fill count, reads follow the scan counter
  assign ram_waddr = cnt_r[IDX_W-1:0];
  assign ram_raddr = idx_r[IDX_W-1:0];
  assign ram_wdata = '{kind:   in_word.kw_kind,
                       offset: in_word.entry_offset,
                       line:   in_word.entry_line,
                       indent: in_word.entry_indent};

  assign more    = (idx_r < cnt_r);
  assign close_k = closer_of(ram_rdata.kind);

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    dv_nxt    = dv_r;
    didx_nxt  = didx_r;
    tally_nxt = tally_r;
    depth_nxt = depth_r;
    kind_nxt  = kind_r;
    open_nxt  = open_r;
    close_nxt = close_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          unique case (in_word.req_type)
            REQ_APPEND: begin
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                res_nxt.status = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              state_nxt = ST_DONE;
            end
            REQ_COUNT: begin
              kind_nxt  = in_word.kw_kind;
              idx_nxt   = '0;
              dv_nxt    = 1'b0;
              tally_nxt = '0;
              state_nxt = ST_COUNT;
            end
            REQ_FIND: begin
              if (START_CMP_W'(in_word.start_index) >= START_CMP_W'(cnt_r)) begin
                res_nxt.status = STAT_BAD_START;
                state_nxt      = ST_DONE;
              end else begin
                idx_nxt   = CNT_W'(in_word.start_index);
                state_nxt = ST_FOPEN;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // count scan: one entry read per cycle, tallied from the registered read data
      ST_COUNT: begin
        if (dv_r && (kind_r == KIND_NONE || ram_rdata.kind == kind_r)) begin
          tally_nxt = tally_r + 1'b1;
        end
        if (more) begin
          idx_nxt = idx_r + 1'b1;
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        if (!dv_r && !more) begin
          if (SAT_W'(tally_r) > SAT_W'(COUNT_MAX)) begin
            res_nxt.count_out = 7'(COUNT_MAX);
          end else begin
            res_nxt.count_out = 7'(tally_r);
          end
          state_nxt = ST_DONE;
        end
      end

      // read the opening record
      ST_FOPEN: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_FKIND;
      end

      // pick the closer for the opener
      ST_FKIND: begin
        if (close_k == KIND_NONE) begin
          res_nxt.status = STAT_NOT_FOUND;
          state_nxt      = ST_DONE;
        end else begin
          open_nxt  = ram_rdata.kind;
          close_nxt = close_k;
          depth_nxt = '0;
          dv_nxt    = 1'b0;
          state_nxt = ST_FSCAN;
        end
      end

      // forward scan with depth counter
      ST_FSCAN: begin
        if (dv_r && ram_rdata.kind == close_r && depth_r == '0) begin
          res_nxt.status       = STAT_OK;
          res_nxt.match_index  = 6'(didx_r);
          res_nxt.match_offset = ram_rdata.offset;
          res_nxt.match_line   = ram_rdata.line;
          res_nxt.match_indent = ram_rdata.indent;
          dv_nxt               = 1'b0;
          state_nxt            = ST_DONE;
        end else begin
          if (dv_r && ram_rdata.kind == open_r) begin
            depth_nxt = depth_r + 1'b1;
          end else if (dv_r && ram_rdata.kind == close_r) begin
            depth_nxt = depth_r - 1'b1;
          end
          if (more) begin
            idx_nxt  = idx_r + 1'b1;
            didx_nxt = idx_r[IDX_W-1:0];
            dv_nxt   = 1'b1;
          end else begin
            dv_nxt = 1'b0;
          end
          if (!dv_r && !more) begin
            res_nxt.status = STAT_NOT_FOUND;
            state_nxt      = ST_DONE;
          end
        end
      end

      // hold the word until the output stage takes it
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
    end
    idx_r   <= idx_nxt;
    didx_r  <= didx_nxt;
    tally_r <= tally_nxt;
    depth_r <= depth_nxt;
    kind_r  <= kind_nxt;
    open_r  <= open_nxt;
    close_r <= close_nxt;
    res_r   <= res_nxt;
  end

`ifndef ASSERT_OFF
  // fill count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // a table write always grows the fill count by one
  a_we_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("write without fill count step");

  // writes happen only when a new word is taken
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE && in_valid))
    else $error("table write outside request start");

  // nesting depth stays below the number of stored records
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FSCAN) |-> (depth_r < cnt_r))
    else $error("nesting depth out of range");
`endif

endmodule

`default_nettype wire

>>> sv/keyword_table_bracket_match.sv
// top level: keyword table with bracket matching, sequencer, record ram and output register
`default_nettype none

// Keyword table with bracket matching. Holds up to TABLE_DEPTH keyword records
// (kind, offset, line, indent) in one ram and serves one request word at a
// time. Append and clear finish without a scan, while count scans the stored
// records and find-match scans onward from start_index: both scans read
// one record a cycle through the single read port of the record ram and run
// it through one compare unit. in_stall is high while a request is being
// worked on and until its result moves to the output register. The result word
// sits in an output register, so the next request is taken while a finished word still waits on out_stall.

module keyword_table_bracket_match
  import kwtbl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  seq_res_t         res;
  logic             res_take;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  rec_t             ram_wdata;
  rec_t             ram_rdata;
  logic [REC_W-1:0] ram_rdata_raw;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r;

  // request sequencer
  kwtbl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // record storage
  kwtbl_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = rec_t'(ram_rdata_raw);

  // output register loads when empty or being drained
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> test/keyword_table_bracket_match_test.sv
// testbench for the keyword table: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module keyword_table_bracket_match_test;
  import kwtbl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  // predictor copy of the keyword records
  logic [3:0] kind_tbl [TABLE_DEPTH];
  logic [15:0] offset_tbl [TABLE_DEPTH];
  logic [11:0] line_tbl [TABLE_DEPTH];
  logic [7:0] indent_tbl [TABLE_DEPTH];
  int table_fill = 0;

  out_word_t awaited_answers [$];
  logic [3:0] open_closers [$];

  int error_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  keyword_table_bracket_match dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall: random, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [3:0] paired_closer(input logic [3:0] kind);
    case (kind)
      KIND_DO:     return KIND_DONE;
      KIND_IF:     return KIND_FI;
      KIND_THEN:   return KIND_FI;
      KIND_CASE:   return KIND_ESAC;
      KIND_OBRACE: return KIND_CBRACE;
      KIND_OPAREN: return KIND_CPAREN;
      default:     return KIND_NONE;
    endcase
  endfunction

  // answer to one request, updating the predicted record store
  function automatic out_word_t answer_for(input in_word_t w);
    out_word_t r;
    int n;
    int j;
    int depth;
    logic [3:0] opener;
    logic [3:0] closer;
    r = '0;
    r.status = STAT_OK;
    case (w.req_type)
      REQ_APPEND: begin
        if (table_fill >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          kind_tbl[table_fill] = w.kw_kind;
          offset_tbl[table_fill] = w.entry_offset;
          line_tbl[table_fill] = w.entry_line;
          indent_tbl[table_fill] = w.entry_indent;
          table_fill++;
        end
      end
      REQ_COUNT: begin
        n = 0;
        for (j = 0; j < table_fill; j++)
          if (w.kw_kind == KIND_NONE || kind_tbl[j] == w.kw_kind) n++;
        r.count_out = (n > COUNT_MAX) ? 7'(COUNT_MAX) : 7'(n);
      end
      REQ_FIND: begin
        if (int'(w.start_index) >= table_fill) begin
          r.status = STAT_BAD_START;
        end else begin
          opener = kind_tbl[w.start_index];
          closer = paired_closer(opener);
          depth = 0;
          r.status = STAT_NOT_FOUND;
          if (closer != KIND_NONE) begin
            for (j = int'(w.start_index) + 1; j < table_fill && r.status != STAT_OK; j++) begin
              if (kind_tbl[j] == opener) begin
                depth++;
              end else if (kind_tbl[j] == closer && depth > 0) begin
                depth--;
              end else if (kind_tbl[j] == closer) begin
                r.status = STAT_OK;
                r.match_index = 6'(j);
                r.match_offset = offset_tbl[j];
                r.match_line = line_tbl[j];
                r.match_indent = indent_tbl[j];
              end
            end
          end
        end
      end
      default: table_fill = 0;
    endcase
    return r;
  endfunction

  function automatic in_word_t request(input logic [1:0] req, input logic [3:0] kind,
                                       input logic [15:0] offset, input logic [11:0] line,
                                       input logic [7:0] indent, input logic [5:0] start);
    in_word_t w;
    w.req_type = req;
    w.kw_kind = kind;
    w.entry_offset = offset;
    w.entry_line = line;
    w.entry_indent = indent;
    w.start_index = start;
    return w;
  endfunction

  function automatic string describe(input out_word_t w);
    return $sformatf("status %0d count %0d index %0d offset %h line %h indent %h",
                     w.status, w.count_out, w.match_index, w.match_offset,
                     w.match_line, w.match_indent);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk) begin : check_answers
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_answers.size() == 0) begin
        flag_error({"unexpected result word: ", describe(out_word)});
      end else begin
        want = awaited_answers.pop_front();
        if (out_word.status !== want.status || out_word.count_out !== want.count_out ||
            out_word.match_index !== want.match_index ||
            out_word.match_offset !== want.match_offset ||
            out_word.match_line !== want.match_line ||
            out_word.match_indent !== want.match_indent) begin
          flag_error({"mismatch, expected ", describe(want), "; got ", describe(out_word)});
        end
      end
    end
  end

  // offer one word, with a random gap first, and predict once it is taken
  task automatic send_word(input in_word_t w);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_answers.push_back(answer_for(w));
  endtask

  // sender pauses until every result is back
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    gap_pct = sender_pct;
    stall_pct <= receiver_pct;
  endtask

  // mostly nested opener/closer sequences with random content, plus noise
  task automatic send_random_request();
    in_word_t w;
    int pick;
    pick = $urandom_range(99);
    w = request(REQ_COUNT, 4'($urandom), 16'($urandom), 12'($urandom), 8'($urandom),
                6'($urandom));
    if (pick < 55) begin
      if (table_fill >= TABLE_DEPTH && $urandom_range(3) != 0) begin
        w.req_type = REQ_CLEAR;
        open_closers.delete();
      end else begin
        w.req_type = REQ_APPEND;
        if (pick >= 6 && open_closers.size() != 0 && $urandom_range(1) == 0) begin
          w.kw_kind = open_closers.pop_back();
        end else if (pick >= 6) begin
          w.kw_kind = 4'($urandom_range(KIND_CPAREN, KIND_DO));
          while (paired_closer(w.kw_kind) == KIND_NONE)
            w.kw_kind = 4'($urandom_range(KIND_CPAREN, KIND_DO));
          open_closers.push_back(paired_closer(w.kw_kind));
        end
      end
    end else if (pick < 80) begin
      w.req_type = REQ_FIND;
      if (table_fill > 0 && pick < 77) w.start_index = 6'($urandom_range(table_fill - 1));
    end else if (pick < 98) begin
      if (pick < 84) w.kw_kind = KIND_NONE;
    end else begin
      w.req_type = REQ_CLEAR;
      open_closers.delete();
    end
    send_word(w);
  endtask

  // requests on an empty store
  task automatic test_empty_table();
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd63));
    send_word(request(REQ_COUNT, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_CLEAR, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
  endtask

  // every pair but parens, nesting of one kind, non-openers, missing closer, bad start
  task automatic test_pairs_and_nesting();
    send_word(request(REQ_APPEND, KIND_DO, 16'hffff, 12'hfff, 8'hff, 6'd0));
    send_word(request(REQ_APPEND, KIND_IF, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_APPEND, KIND_THEN, 16'h1234, 12'h056, 8'h07, 6'd0));
    send_word(request(REQ_APPEND, KIND_FI, 16'h8001, 12'h801, 8'h81, 6'd0));
    send_word(request(REQ_APPEND, KIND_DONE, 16'h7ffe, 12'h7fe, 8'h7e, 6'd0));
    send_word(request(REQ_APPEND, KIND_CASE, 16'h0010, 12'h011, 8'h12, 6'd0));
    send_word(request(REQ_APPEND, KIND_OBRACE, 16'h0020, 12'h021, 8'h22, 6'd0));
    send_word(request(REQ_APPEND, KIND_OBRACE, 16'h0030, 12'h031, 8'h32, 6'd0));
    send_word(request(REQ_APPEND, KIND_CBRACE, 16'h0040, 12'h041, 8'h42, 6'd0));
    send_word(request(REQ_APPEND, KIND_CBRACE, 16'h0050, 12'h051, 8'h52, 6'd0));
    send_word(request(REQ_APPEND, KIND_ESAC, 16'h0060, 12'h061, 8'h62, 6'd0));
    send_word(request(REQ_APPEND, KIND_OPAREN, 16'h0070, 12'h071, 8'h72, 6'd0));
    send_word(request(REQ_APPEND, 4'hf, 16'h0080, 12'h081, 8'h82, 6'd0));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd1));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd2));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd3));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd5));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd6));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd11));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd13));
    send_word(request(REQ_COUNT, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_COUNT, KIND_OBRACE, 16'h0000, 12'h000, 8'h00, 6'd0));
  endtask

  // fill the store, append past the end, then clear
  task automatic test_table_full();
    int i;
    send_word(request(REQ_CLEAR, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    for (i = 0; i < TABLE_DEPTH + 2; i++)
      send_word(request(REQ_APPEND, 4'($urandom), 16'($urandom), 12'($urandom),
                        8'($urandom), 6'd0));
    send_word(request(REQ_COUNT, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd63));
    send_word(request(REQ_FIND, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_CLEAR, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    send_word(request(REQ_COUNT, KIND_NONE, 16'h0000, 12'h000, 8'h00, 6'd0));
    wait_for_answers();
    open_closers.delete();
  endtask

  task automatic test_random_requests(input int n);
    int i;
    for (i = 0; i < n; i++) send_random_request();
    wait_for_answers();
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_output_hold();
    int i;
    gap_pct = 0;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 12; i++) send_random_request();
    wait_for_answers();
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(31, 71);
    test_empty_table();
    test_pairs_and_nesting();
    test_table_full();
    test_random_requests(165);
    set_idling(71, 31);
    test_random_requests(165);
    test_output_hold();
    set_idling(0, 0);
    test_random_requests(165);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
